// ===== rtl/rnc_pkg.sv =====
// Shared types, constants and microcode table of the Roman numeral converter.
`default_nettype none
package rnc_pkg;

   localparam int unsigned PC_W    = 5;
   localparam int unsigned VALUE_W = 12;
   localparam int unsigned SUM_W   = 14;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned AMT_W   = 10;

   localparam logic [VALUE_W-1:0] ENC_MAX = VALUE_W'(3999);
   localparam logic [SUM_W-1:0]   SUM_MAX = SUM_W'(16383);

   // microcode addresses
   localparam logic [PC_W-1:0] UA_CHECK     = PC_W'(0);
   localparam logic [PC_W-1:0] UA_M         = PC_W'(1);
   localparam logic [PC_W-1:0] UA_CM        = PC_W'(2);
   localparam logic [PC_W-1:0] UA_CM_M      = PC_W'(3);
   localparam logic [PC_W-1:0] UA_D         = PC_W'(4);
   localparam logic [PC_W-1:0] UA_CD        = PC_W'(5);
   localparam logic [PC_W-1:0] UA_CD_D      = PC_W'(6);
   localparam logic [PC_W-1:0] UA_C         = PC_W'(7);
   localparam logic [PC_W-1:0] UA_XC        = PC_W'(8);
   localparam logic [PC_W-1:0] UA_XC_C      = PC_W'(9);
   localparam logic [PC_W-1:0] UA_L         = PC_W'(10);
   localparam logic [PC_W-1:0] UA_XL        = PC_W'(11);
   localparam logic [PC_W-1:0] UA_XL_L      = PC_W'(12);
   localparam logic [PC_W-1:0] UA_X         = PC_W'(13);
   localparam logic [PC_W-1:0] UA_IX        = PC_W'(14);
   localparam logic [PC_W-1:0] UA_IX_X      = PC_W'(15);
   localparam logic [PC_W-1:0] UA_V         = PC_W'(16);
   localparam logic [PC_W-1:0] UA_IV        = PC_W'(17);
   localparam logic [PC_W-1:0] UA_IV_V      = PC_W'(18);
   localparam logic [PC_W-1:0] UA_I         = PC_W'(19);
   localparam logic [PC_W-1:0] UA_DEC_STEP  = PC_W'(20);
   localparam logic [PC_W-1:0] UA_DEC_FINAL = PC_W'(21);

   typedef enum logic [2:0] {
      LC_I, LC_V, LC_X, LC_L, LC_C, LC_D, LC_M
   } letter_code_type;

   typedef enum logic [3:0] {
      K1000, K900, K500, K400, K100, K90, K50, K40, K10, K9, K5, K4, K1
   } konst_type;

   typedef enum logic [1:0] {
      COND_ALWAYS, COND_BAD, COND_GE, COND_LAST
   } cond_type;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_EMIT_BAD, ACT_EMIT, ACT_EMIT_SUB, ACT_DEC_STEP, ACT_DEC_FINAL
   } act_type;

   typedef enum logic {
      SEQ_IDLE, SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      cond_type        cond;
      act_type         act;
      letter_code_type letter;
      konst_type       konst;
      logic [PC_W-1:0] jump_t;
      logic [PC_W-1:0] jump_f;
      logic            end_f;
   } ucode_word_type;

   typedef struct packed {
      logic            fire;
      act_type         act;
      letter_code_type letter;
      konst_type       konst;
   } rnc_ctrl_type;

   typedef struct packed {
      logic bad;
      logic ge;
      logic rem_eq;
      logic last;
      logic emit_ok;
   } rnc_status_type;

   function automatic ucode_word_type mk(input cond_type c, input act_type a,
                                         input letter_code_type l, input konst_type k,
                                         input logic [PC_W-1:0] jt,
                                         input logic [PC_W-1:0] jf, input logic e);
      ucode_word_type w;
      w = '{cond: c, act: a, letter: l, konst: k, jump_t: jt, jump_f: jf, end_f: e};
      return w;
   endfunction

   // greedy Roman encode, then the two-step letter decode
   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      unique case (pc)
         UA_CHECK:     w = mk(COND_BAD, ACT_EMIT_BAD, LC_I, K1, UA_CHECK, UA_M, 1'b0);
         UA_M:         w = mk(COND_GE, ACT_EMIT_SUB, LC_M, K1000, UA_M, UA_CM, 1'b0);
         UA_CM:        w = mk(COND_GE, ACT_EMIT, LC_C, K900, UA_CM_M, UA_D, 1'b0);
         UA_CM_M:      w = mk(COND_ALWAYS, ACT_EMIT_SUB, LC_M, K900, UA_XC, UA_XC, 1'b0);
         UA_D:         w = mk(COND_GE, ACT_EMIT_SUB, LC_D, K500, UA_C, UA_CD, 1'b0);
         UA_CD:        w = mk(COND_GE, ACT_EMIT, LC_C, K400, UA_CD_D, UA_C, 1'b0);
         UA_CD_D:      w = mk(COND_ALWAYS, ACT_EMIT_SUB, LC_D, K400, UA_XC, UA_XC, 1'b0);
         UA_C:         w = mk(COND_GE, ACT_EMIT_SUB, LC_C, K100, UA_C, UA_XC, 1'b0);
         UA_XC:        w = mk(COND_GE, ACT_EMIT, LC_X, K90, UA_XC_C, UA_L, 1'b0);
         UA_XC_C:      w = mk(COND_ALWAYS, ACT_EMIT_SUB, LC_C, K90, UA_IX, UA_IX, 1'b0);
         UA_L:         w = mk(COND_GE, ACT_EMIT_SUB, LC_L, K50, UA_X, UA_XL, 1'b0);
         UA_XL:        w = mk(COND_GE, ACT_EMIT, LC_X, K40, UA_XL_L, UA_X, 1'b0);
         UA_XL_L:      w = mk(COND_ALWAYS, ACT_EMIT_SUB, LC_L, K40, UA_IX, UA_IX, 1'b0);
         UA_X:         w = mk(COND_GE, ACT_EMIT_SUB, LC_X, K10, UA_X, UA_IX, 1'b0);
         UA_IX:        w = mk(COND_GE, ACT_EMIT, LC_I, K9, UA_IX_X, UA_V, 1'b0);
         UA_IX_X:      w = mk(COND_ALWAYS, ACT_EMIT_SUB, LC_X, K9, UA_I, UA_I, 1'b0);
         UA_V:         w = mk(COND_GE, ACT_EMIT_SUB, LC_V, K5, UA_I, UA_IV, 1'b0);
         UA_IV:        w = mk(COND_GE, ACT_EMIT, LC_I, K4, UA_IV_V, UA_I, 1'b0);
         UA_IV_V:      w = mk(COND_ALWAYS, ACT_EMIT_SUB, LC_V, K4, UA_I, UA_I, 1'b0);
         UA_I:         w = mk(COND_GE, ACT_EMIT_SUB, LC_I, K1, UA_I, UA_I, 1'b0);
         UA_DEC_STEP:  w = mk(COND_ALWAYS, ACT_DEC_STEP, LC_I, K1, UA_DEC_FINAL,
                              UA_DEC_FINAL, 1'b0);
         UA_DEC_FINAL: w = mk(COND_LAST, ACT_DEC_FINAL, LC_I, K1, UA_DEC_FINAL,
                              UA_DEC_FINAL, 1'b1);
         default:      w = mk(COND_ALWAYS, ACT_NONE, LC_I, K1, UA_CHECK, UA_CHECK, 1'b0);
      endcase
      return w;
   endfunction

   function automatic logic [VALUE_W-1:0] konst_value(input konst_type k);
      logic [VALUE_W-1:0] v;
      unique case (k)
         K1000:   v = VALUE_W'(1000);
         K900:    v = VALUE_W'(900);
         K500:    v = VALUE_W'(500);
         K400:    v = VALUE_W'(400);
         K100:    v = VALUE_W'(100);
         K90:     v = VALUE_W'(90);
         K50:     v = VALUE_W'(50);
         K40:     v = VALUE_W'(40);
         K10:     v = VALUE_W'(10);
         K9:      v = VALUE_W'(9);
         K5:      v = VALUE_W'(5);
         K4:      v = VALUE_W'(4);
         K1:      v = VALUE_W'(1);
         default: v = VALUE_W'(1);
      endcase
      return v;
   endfunction

   function automatic logic [CHAR_W-1:0] letter_char(input letter_code_type c);
      logic [CHAR_W-1:0] ch;
      unique case (c)
         LC_I:    ch = "I";
         LC_V:    ch = "V";
         LC_X:    ch = "X";
         LC_L:    ch = "L";
         LC_C:    ch = "C";
         LC_D:    ch = "D";
         default: ch = "M";
      endcase
      return ch;
   endfunction

   function automatic logic [AMT_W-1:0] letter_value(input letter_code_type c);
      logic [AMT_W-1:0] v;
      unique case (c)
         LC_I:    v = AMT_W'(1);
         LC_V:    v = AMT_W'(5);
         LC_X:    v = AMT_W'(10);
         LC_L:    v = AMT_W'(50);
         LC_C:    v = AMT_W'(100);
         LC_D:    v = AMT_W'(500);
         default: v = AMT_W'(1000);
      endcase
      return v;
   endfunction

   // value of a subtractive pair, keyed by its larger letter
   function automatic logic [AMT_W-1:0] pair_value(input letter_code_type c);
      logic [AMT_W-1:0] v;
      unique case (c)
         LC_V:    v = AMT_W'(4);
         LC_X:    v = AMT_W'(9);
         LC_L:    v = AMT_W'(40);
         LC_C:    v = AMT_W'(90);
         LC_D:    v = AMT_W'(400);
         default: v = AMT_W'(900);
      endcase
      return v;
   endfunction

   // anything outside I V X L C D reads as M
   function automatic letter_code_type char_code(input logic [CHAR_W-1:0] ch);
      letter_code_type c;
      unique case (ch)
         "I":     c = LC_I;
         "V":     c = LC_V;
         "X":     c = LC_X;
         "L":     c = LC_L;
         "C":     c = LC_C;
         "D":     c = LC_D;
         default: c = LC_M;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rnc_sequencer.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`default_nettype none
module rnc_sequencer
   import rnc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic           start_type,
   input  wire rnc_status_type status,
   output rnc_ctrl_type        ctrl,
   output logic                busy
);

   seq_state_type   state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_word_type  word;
   logic            cond_true;
   logic            emits;
   logic            step;
   logic            finish;

   always_comb begin
      word = ucode_rom(pc_ff);
      unique case (word.cond)
         COND_ALWAYS: cond_true = 1'b1;
         COND_BAD:    cond_true = status.bad;
         COND_GE:     cond_true = status.ge;
         COND_LAST:   cond_true = status.last;
         default:     cond_true = 1'b0;
      endcase
      emits = cond_true && (word.act == ACT_EMIT_BAD || word.act == ACT_EMIT ||
                            word.act == ACT_EMIT_SUB || word.act == ACT_DEC_FINAL);
      step  = (state_ff == SEQ_RUN) && (!emits || status.emit_ok);
      finish = step && ((cond_true && (word.act == ACT_EMIT_BAD ||
                                       word.act == ACT_DEC_FINAL ||
                                       (word.act == ACT_EMIT_SUB && status.rem_eq))) ||
                        (!cond_true && word.end_f));
   end

   // next state
   always_comb begin
      unique case (state_ff)
         SEQ_IDLE: state_in = start ? SEQ_RUN : SEQ_IDLE;
         SEQ_RUN:  state_in = finish ? SEQ_IDLE : SEQ_RUN;
         default:  state_in = SEQ_IDLE;
      endcase
      priority if (start) begin
         pc_in = start_type ? UA_DEC_STEP : UA_CHECK;
      end else if (step) begin
         pc_in = cond_true ? word.jump_t : word.jump_f;
      end else begin
         pc_in = pc_ff;
      end
   end

   // outputs
   always_comb begin
      busy        = (state_ff == SEQ_RUN);
      ctrl.fire   = step && cond_true;
      ctrl.act    = word.act;
      ctrl.letter = word.letter;
      ctrl.konst  = word.konst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= UA_CHECK;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rnc_datapath.sv =====
// Datapath: remainder compare/subtract, decode accumulator and response register.
`default_nettype none
module rnc_datapath
   import rnc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [VALUE_W-1:0] value_in,
   input  wire logic [CHAR_W-1:0]  letter_in,
   input  wire logic               letter_last,
   input  wire rnc_ctrl_type       ctrl,
   input  wire logic               rsp_stall,
   output rnc_status_type          status,
   output logic                    rsp_valid,
   output logic [CHAR_W-1:0]       rsp_letter_out,
   output logic [SUM_W-1:0]        rsp_value_out,
   output logic                    rsp_result_kind,
   output logic                    rsp_out_last,
   output logic                    rsp_error_flag
);

   logic [VALUE_W-1:0] rem_ff, rem_in;
   letter_code_type    code_ff;
   logic               last_ff;

   logic [SUM_W-1:0]   sum_ff, sum_in;
   letter_code_type    pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               sat_ff, sat_in;

   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  letter_ff, letter_in_r;
   logic [SUM_W-1:0]   value_ff, value_in_r;
   logic               kind_ff, kind_in;
   logic               olast_ff, olast_in;
   logic               err_ff, err_in;

   logic [VALUE_W-1:0] kval;
   logic [2:0]         c_bits;
   logic [2:0]         p_bits;
   logic               pair;
   logic [AMT_W-1:0]   amt;
   logic [SUM_W:0]     total;
   logic [SUM_W-1:0]   sum_new;
   logic               sat_new;
   logic               load;

   always_comb begin
      kval   = konst_value(ctrl.konst);
      c_bits = code_ff;
      p_bits = pend_ff;

      status.bad     = (rem_ff == '0) || (rem_ff > ENC_MAX);
      status.ge      = (rem_ff >= kval);
      status.rem_eq  = (rem_ff == kval);
      status.last    = last_ff;
      status.emit_ok = !valid_ff || !rsp_stall;

      pair = (code_ff == LC_I || code_ff == LC_X || code_ff == LC_C) &&
             (p_bits == c_bits + 3'd1 || p_bits == c_bits + 3'd2);

      amt    = (ctrl.act == ACT_DEC_STEP && pair) ? pair_value(pend_ff)
                                                  : letter_value(pend_ff);
      total  = {1'b0, sum_ff} + (SUM_W + 1)'(amt);
      sum_new = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
      sat_new = sat_ff || total[SUM_W];

      rem_in = rem_ff;
      if (start) begin
         rem_in = value_in;
      end else if (ctrl.fire && ctrl.act == ACT_EMIT_SUB) begin
         rem_in = rem_ff - kval;
      end

      sum_in        = sum_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      sat_in        = sat_ff;
      if (ctrl.fire && ctrl.act == ACT_DEC_STEP) begin
         if (pend_valid_ff) begin
            sum_in        = sum_new;
            sat_in        = sat_new;
            pend_valid_in = !pair;
            pend_in       = pair ? pend_ff : code_ff;
         end else begin
            pend_in       = code_ff;
            pend_valid_in = 1'b1;
         end
      end else if (ctrl.fire && ctrl.act == ACT_DEC_FINAL) begin
         sum_in        = '0;
         pend_in       = LC_I;
         pend_valid_in = 1'b0;
         sat_in        = 1'b0;
      end

      load = ctrl.fire && (ctrl.act == ACT_EMIT_BAD || ctrl.act == ACT_EMIT ||
                           ctrl.act == ACT_EMIT_SUB || ctrl.act == ACT_DEC_FINAL);
      valid_in    = load || (valid_ff && rsp_stall);
      letter_in_r = letter_ff;
      value_in_r  = value_ff;
      kind_in     = kind_ff;
      olast_in    = olast_ff;
      err_in      = err_ff;
      if (load) begin
         unique case (ctrl.act)
            ACT_EMIT_BAD: begin
               letter_in_r = '0;
               value_in_r  = '0;
               kind_in     = 1'b0;
               olast_in    = 1'b1;
               err_in      = (rem_ff > ENC_MAX);
            end
            ACT_EMIT, ACT_EMIT_SUB: begin
               letter_in_r = letter_char(ctrl.letter);
               value_in_r  = '0;
               kind_in     = 1'b0;
               olast_in    = (ctrl.act == ACT_EMIT_SUB) && status.rem_eq;
               err_in      = 1'b0;
            end
            default: begin
               letter_in_r = '0;
               value_in_r  = pend_valid_ff ? sum_new : sum_ff;
               kind_in     = 1'b1;
               olast_in    = 1'b1;
               err_in      = pend_valid_ff ? sat_new : sat_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         code_ff <= char_code(letter_in);
         last_ff <= letter_last;
      end
      rem_ff    <= rem_in;
      letter_ff <= letter_in_r;
      value_ff  <= value_in_r;
      kind_ff   <= kind_in;
      olast_ff  <= olast_in;
      err_ff    <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         pend_ff       <= LC_I;
         pend_valid_ff <= 1'b0;
         sat_ff        <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         sum_ff        <= sum_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         sat_ff        <= sat_in;
         valid_ff      <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_letter_out  = letter_ff;
   assign rsp_value_out   = value_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_last    = olast_ff;
   assign rsp_error_flag  = err_ff;

endmodule
`default_nettype wire

// ===== rtl/roman_numeral_converter_core.sv =====
// Top level of the two-way Roman numeral converter.
`default_nettype none
// Converts a binary value (1..3999) to Roman letters, most significant first, one
// letter per response, or sums Roman letters fed rightmost first and responds with
// the value on the letter marked last. A small control ROM steps a shared
// compare/subtract unit and a saturating 14-bit accumulator; one request is in
// work at a time. Encode steps through the range check, one step per letter and
// each greedy test that falls through (at most twelve); zero or out-of-range values
// end at the range check. Each decode letter takes two microcode steps. The next
// request is taken in the cycle after the last step; a stalled response holds the
// sequencer only when it has to emit.
module roman_numeral_converter_core
   import rnc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_type,
   input  wire logic [VALUE_W-1:0] req_value_in,
   input  wire logic [CHAR_W-1:0]  req_letter_in,
   input  wire logic               req_letter_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [CHAR_W-1:0]       rsp_letter_out,
   output logic [SUM_W-1:0]        rsp_value_out,
   output logic                    rsp_result_kind,
   output logic                    rsp_out_last,
   output logic                    rsp_error_flag
);

   rnc_ctrl_type   ctrl;
   rnc_status_type status;
   logic           busy;
   logic           start;

   assign req_stall = busy || reset;
   assign start     = req_valid && !req_stall;

   rnc_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_type (req_type),
      .status     (status),
      .ctrl       (ctrl),
      .busy       (busy)
   );

   rnc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .value_in        (req_value_in),
      .letter_in       (req_letter_in),
      .letter_last     (req_letter_last),
      .ctrl            (ctrl),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_letter_out  (rsp_letter_out),
      .rsp_value_out   (rsp_value_out),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_last    (rsp_out_last),
      .rsp_error_flag  (rsp_error_flag)
   );

endmodule
`default_nettype wire

// ===== rtl/rnc_checker.sv =====
// Port-level assertions for the Roman numeral converter, bound to the top level.
`default_nettype none
module rnc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_letter_out,
   input wire logic [13:0] rsp_value_out,
   input wire logic        rsp_result_kind,
   input wire logic        rsp_out_last,
   input wire logic        rsp_error_flag
);

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_letter_out) &&
                                 $stable(rsp_value_out) && $stable(rsp_out_last))
      else $error("stalled response changed");

   a_decode_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_letter_out == '0 && rsp_out_last)
      else $error("decode response malformed");

   a_encode_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind && rsp_error_flag |->
         rsp_letter_out == '0 && rsp_out_last && rsp_value_out == '0)
      else $error("encode error response malformed");

endmodule

bind roman_numeral_converter_core rnc_checker u_checker (.*);
`default_nettype wire
